// ----- design/i8080ag_pkg.sv -----
// Shared types, opcode constants and flag helpers for the 8080 arithmetic group unit.
package i8080ag_pkg;

	localparam logic [7:0] OPC_ADI = 8'hC6;
	localparam logic [7:0] OPC_ACI = 8'hCE;
	localparam logic [7:0] OPC_SUI = 8'hD6;
	localparam logic [7:0] OPC_SBI = 8'hDE;
	localparam logic [7:0] OPC_DAA = 8'h27;

	localparam logic [7:0] MASK_INRDCR = 8'hC6;
	localparam logic [7:0] PATT_INRDCR = 8'h04;
	localparam logic [7:0] MASK_INXDCX = 8'hC7;
	localparam logic [7:0] PATT_INXDCX = 8'h03;
	localparam logic [7:0] MASK_DAD    = 8'hCF;
	localparam logic [7:0] PATT_DAD    = 8'h09;

	localparam logic [2:0] REG_H = 3'd4;
	localparam logic [2:0] REG_L = 3'd5;
	localparam logic [2:0] REG_M = 3'd6;
	localparam logic [2:0] REG_A = 3'd7;

	localparam logic [1:0] PAIR_BC = 2'd0;
	localparam logic [1:0] PAIR_DE = 2'd1;
	localparam logic [1:0] PAIR_HL = 2'd2;
	localparam logic [1:0] PAIR_SP = 2'd3;

	localparam logic [1:0] ALU_ADD = 2'd0;
	localparam logic [1:0] ALU_ADC = 2'd1;
	localparam logic [1:0] ALU_SUB = 2'd2;
	localparam logic [1:0] ALU_SBB = 2'd3;

	localparam logic [3:0] BCD_MAX_DIGIT = 4'h9;
	localparam logic [7:0] DAA_LO_ADJ    = 8'h06;
	localparam logic [7:0] DAA_HI_ADJ    = 8'h60;

	localparam int FLAG_CY = 0;
	localparam int FLAG_P  = 1;
	localparam int FLAG_AC = 2;
	localparam int FLAG_Z  = 3;
	localparam int FLAG_S  = 4;

	typedef struct packed {
		logic [7:0][7:0] rf;
		logic [15:0]     sp;
		logic [4:0]      flags;
	} cpu_state_t;

	typedef struct packed {
		logic [7:0]  acc;
		logic [4:0]  flag_bits;
		logic [15:0] hl_pair;
		logic        mem_write;
		logic [15:0] mem_addr;
		logic [7:0]  mem_wdata;
		logic        unsupported;
	} result_t;

	// sign, zero and even-parity bits in their flag positions
	function automatic logic [4:0] szp_bits(input logic [7:0] v);
		logic [4:0] f;
		f = '0;
		f[FLAG_S] = v[7];
		f[FLAG_Z] = (v == 8'h00);
		f[FLAG_P] = ~^v;
		return f;
	endfunction

endpackage

// ----- design/i8080ag_req_if.sv -----
// Request channel: one opcode beat with the byte at HL and the immediate byte.
interface i8080ag_req_if;
	logic       valid;
	logic       ready;
	logic [7:0] func;
	logic [7:0] mem_data;
	logic [7:0] imm_data;

	modport source (output valid, output func, output mem_data, output imm_data, input ready);
	modport sink (input valid, input func, input mem_data, input imm_data, output ready);
endinterface

// ----- design/i8080ag_rsp_if.sv -----
// Response channel: accumulator, flags, HL and memory write of one executed beat.
interface i8080ag_rsp_if;
	logic        valid;
	logic        ready;
	logic [7:0]  acc;
	logic [4:0]  flag_bits;
	logic [15:0] hl_pair;
	logic        mem_write;
	logic [15:0] mem_addr;
	logic [7:0]  mem_wdata;
	logic        unsupported;

	modport source (output valid, output acc, output flag_bits, output hl_pair,
		output mem_write, output mem_addr, output mem_wdata, output unsupported,
		input ready);
	modport sink (input valid, input acc, input flag_bits, input hl_pair,
		input mem_write, input mem_addr, input mem_wdata, input unsupported,
		output ready);
endinterface

// ----- design/i8080ag_exec.sv -----
// Execute logic: next architectural state and result for one arithmetic-group opcode.
module i8080ag_exec
	import i8080ag_pkg::*;
(
	input  logic [7:0] func,
	input  logic [7:0] mem_data,
	input  logic [7:0] imm_data,
	input  cpu_state_t cur,
	output cpu_state_t nxt,
	output result_t    res
);

	logic [7:0]  a;
	logic        cy;
	logic [15:0] hl0;
	logic        is_arith, is_incdec, is_inxdcx, is_dad, is_daa;

	// arithmetic
	logic [1:0] aop;
	logic [2:0] src;
	logic       sub;
	logic [7:0] opnd, opx;
	logic       cin;
	logic [8:0] sum9;
	logic [4:0] nib;
	logic       ar_c;

	// increment / decrement
	logic [2:0] dst;
	logic [7:0] idv, idr;
	logic       id_ac;

	// pair ops
	logic [1:0]  rp;
	logic [15:0] pv, pr;
	logic [16:0] dsum;

	// decimal adjust
	logic [3:0] lo, hi;
	logic       corr_lo, corr_hi;
	logic [7:0] corr, dr;
	logic [4:0] dnib;

	function automatic logic [15:0] get_pair(input cpu_state_t s, input logic [1:0] p);
		logic [15:0] v;
		case (p)
			PAIR_BC: v = {s.rf[0], s.rf[1]};
			PAIR_DE: v = {s.rf[2], s.rf[3]};
			PAIR_HL: v = {s.rf[REG_H], s.rf[REG_L]};
			PAIR_SP: v = s.sp;
			default: v = s.sp;
		endcase
		return v;
	endfunction

	always_comb begin
		a   = cur.rf[REG_A];
		cy  = cur.flags[FLAG_CY];
		hl0 = get_pair(cur, PAIR_HL);

		is_arith  = func inside {[8'h80:8'h9F], OPC_ADI, OPC_ACI, OPC_SUI, OPC_SBI};
		is_incdec = (func & MASK_INRDCR) == PATT_INRDCR;
		is_inxdcx = (func & MASK_INXDCX) == PATT_INXDCX;
		is_dad    = (func & MASK_DAD) == PATT_DAD;
		is_daa    = func == OPC_DAA;

		aop = func[4:3];
		src = func[2:0];
		sub = aop[1];
		if (func[7:6] == 2'b11) begin
			opnd = imm_data;
		end else if (src == REG_M) begin
			opnd = mem_data;
		end else begin
			opnd = cur.rf[src];
		end
		opx = sub ? ~opnd : opnd;
		case (aop)
			ALU_ADD: cin = 1'b0;
			ALU_ADC: cin = cy;
			ALU_SUB: cin = 1'b1;
			ALU_SBB: cin = ~cy;
			default: cin = 1'b0;
		endcase
		sum9 = {1'b0, a} + {1'b0, opx} + {8'd0, cin};
		nib  = {1'b0, a[3:0]} + {1'b0, opx[3:0]} + {4'd0, cin};
		ar_c = sum9[8] ^ sub;

		dst = func[5:3];
		idv = (dst == REG_M) ? mem_data : cur.rf[dst];
		idr = func[0] ? idv - 8'd1 : idv + 8'd1;
		id_ac = func[0] ? (idr[3:0] != 4'hF) : (idr[3:0] == 4'h0);

		rp   = func[5:4];
		pv   = get_pair(cur, rp);
		pr   = func[3] ? pv - 16'd1 : pv + 16'd1;
		dsum = {1'b0, pv} + {1'b0, hl0};

		lo = a[3:0];
		hi = a[7:4];
		corr_lo = (lo > BCD_MAX_DIGIT) || cur.flags[FLAG_AC];
		corr_hi = (hi > BCD_MAX_DIGIT) || cy || ((hi >= BCD_MAX_DIGIT) && (lo > BCD_MAX_DIGIT));
		corr = (corr_lo ? DAA_LO_ADJ : 8'h00) | (corr_hi ? DAA_HI_ADJ : 8'h00);
		dr   = a + corr;
		dnib = {1'b0, lo} + {1'b0, corr[3:0]};

		nxt = cur;
		res.mem_write   = 1'b0;
		res.mem_wdata   = 8'h00;
		res.unsupported = 1'b0;
		res.mem_addr    = hl0;

		if (is_arith) begin
			nxt.rf[REG_A] = sum9[7:0];
			nxt.flags = szp_bits(sum9[7:0]);
			nxt.flags[FLAG_AC] = nib[4];
			nxt.flags[FLAG_CY] = ar_c;
		end else if (is_incdec) begin
			if (dst == REG_M) begin
				res.mem_write = 1'b1;
				res.mem_wdata = idr;
			end else begin
				nxt.rf[dst] = idr;
			end
			nxt.flags = szp_bits(idr);
			nxt.flags[FLAG_AC] = id_ac;
			nxt.flags[FLAG_CY] = cy;
		end else if (is_inxdcx) begin
			if (rp == PAIR_SP) begin
				nxt.sp = pr;
			end else begin
				nxt.rf[{rp, 1'b0}] = pr[15:8];
				nxt.rf[{rp, 1'b1}] = pr[7:0];
			end
		end else if (is_dad) begin
			nxt.rf[REG_H] = dsum[15:8];
			nxt.rf[REG_L] = dsum[7:0];
			nxt.flags[FLAG_CY] = dsum[16];
		end else if (is_daa) begin
			nxt.rf[REG_A] = dr;
			nxt.flags = szp_bits(dr);
			nxt.flags[FLAG_AC] = dnib[4];
			nxt.flags[FLAG_CY] = corr_hi | cy;
		end else begin
			res.unsupported = 1'b1;
		end

		res.acc       = nxt.rf[REG_A];
		res.flag_bits = nxt.flags;
		res.hl_pair   = {nxt.rf[REG_H], nxt.rf[REG_L]};
	end

endmodule

// ----- design/i8080_arithmetic_group_unit.sv -----
// Top level of the 8080 arithmetic group unit: register file, input and result stages.
//
// Usage: each beat on req carries one opcode (func), the byte currently stored at
// address HL (mem_data) and the immediate byte (imm_data). The unit keeps B, C, D,
// E, H, L, A, SP and the S Z AC P CY flags, and executes ADD/ADC/SUB/SBB and their
// immediate forms, INR, DCR, INX, DCX, DAD and DAA. Each request gives exactly one
// rsp beat with A, the flags and HL after the instruction, plus the memory write
// of INR M / DCR M (mem_addr is HL before the instruction). Other opcodes leave the
// state alone and come back with unsupported set.
// The input stage registers the request; the execute logic then feeds the result
// stage, which drives rsp valid. Throughput: one instruction per cycle while rsp
// is not stalled; the state read by one instruction is the state written by the one
// before it. Reset clears all registers, SP and flags and empties both stages.
// When rsp is stalled the result stage holds, the input stage fills, and then
// req.ready drops until the receiver takes the waiting beat.
module i8080_arithmetic_group_unit
	import i8080ag_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	i8080ag_req_if.sink   req,
	i8080ag_rsp_if.source rsp
);

	cpu_state_t state_q, state_nxt;
	result_t    res, res_s2;
	logic       v_s1, v_s2;
	logic [7:0] func_s1, mem_s1, imm_s1;
	logic       s2_ready, adv_s1;

	assign s2_ready  = !v_s2 || rsp.ready;
	assign adv_s1    = v_s1 && s2_ready;
	assign req.ready = !v_s1 || s2_ready;

	i8080ag_exec u_exec (
		.func     (func_s1),
		.mem_data (mem_s1),
		.imm_data (imm_s1),
		.cur      (state_q),
		.nxt      (state_nxt),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			state_q <= '0;
		end else begin
			if (req.ready) begin
				v_s1 <= req.valid;
			end
			if (adv_s1) begin
				v_s2    <= 1'b1;
				state_q <= state_nxt;
			end else if (rsp.ready) begin
				v_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			func_s1 <= req.func;
			mem_s1  <= req.mem_data;
			imm_s1  <= req.imm_data;
		end
		if (adv_s1) begin
			res_s2 <= res;
		end
	end

	assign rsp.valid       = v_s2;
	assign rsp.acc         = res_s2.acc;
	assign rsp.flag_bits   = res_s2.flag_bits;
	assign rsp.hl_pair     = res_s2.hl_pair;
	assign rsp.mem_write   = res_s2.mem_write;
	assign rsp.mem_addr    = res_s2.mem_addr;
	assign rsp.mem_wdata   = res_s2.mem_wdata;
	assign rsp.unsupported = res_s2.unsupported;

endmodule
